FILE: rtl/tspe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the transport stream PID payload extractor.
// No dependencies; imported by tspe_parser and ts_pid_payload_extractor_top.
package tspe_pkg;

  // input request: one datagram byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       datagram_start;
  } in_t;

  // result request: payload byte or marker
  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] result_kind;
  } out_t;

  typedef struct packed {
    logic [12:0] target_pid;
    logic [7:0]  rtp_header_bytes;
    logic [7:0]  unit_header_skip;
  } cfg_t;

  typedef struct packed {
    logic valid;
    out_t res;
  } res_t;

  localparam logic [2:0] KIND_PAYLOAD = 3'd0;
  localparam logic [2:0] KIND_END     = 3'd1;
  localparam logic [2:0] KIND_ABANDON = 3'd2;
  localparam logic [2:0] KIND_BAD_AFC = 3'd3;
  localparam logic [2:0] KIND_AF_LONG = 3'd4;

  localparam logic [1:0] CFG_TARGET_PID = 2'd0;
  localparam logic [1:0] CFG_RTP_HEADER = 2'd1;
  localparam logic [1:0] CFG_UNIT_SKIP  = 2'd2;

  localparam logic [12:0] TARGET_PID_RST = 13'h1011;
  localparam logic [7:0]  RTP_HEADER_RST = 8'd12;
  localparam logic [7:0]  UNIT_SKIP_RST  = 8'd14;

  localparam logic [1:0] AFC_PAYLOAD_ONLY = 2'b01;
  localparam logic [1:0] AFC_AF_PAYLOAD   = 2'b11;

  localparam int POS_W = 8;

endpackage

FILE: rtl/tspe_parser.sv
`timescale 1ns / 1ps
// Per-byte header parser and unit tracker: packet position, PID match,
// adaptation field skip and unit skip count. Depends on tspe_pkg.
module tspe_parser
  import tspe_pkg::*;
#(
  parameter int TS_PACKET_BYTES = 188
) (
  input  logic clk,
  input  logic rst,
  input  logic acc,
  input  in_t  in_data,
  input  cfg_t cfg,
  output res_t result
);

  localparam logic [POS_W-1:0] LastPos = POS_W'(TS_PACKET_BYTES - 1);
  localparam logic [7:0]       AfMax   = 8'(TS_PACKET_BYTES - 5);

  logic [7:0]       datagram_pos, datagram_pos_next;
  logic [POS_W-1:0] packet_pos, packet_pos_next;
  logic [5:0]       pid_high_and_start, pid_high_and_start_next;
  logic             packet_selected, packet_selected_next;
  logic [1:0]       adaptation_mode, adaptation_mode_next;
  logic [7:0]       payload_start_pos, payload_start_pos_next;
  logic [7:0]       unit_byte_count, unit_byte_count_next;
  logic             unit_open, unit_open_next;

  logic [POS_W-1:0] p;
  logic [7:0]       b;
  logic [7:0]       dpos;
  logic             sel;
  logic [1:0]       afc;

  always_comb begin
    b   = in_data.data_byte;
    dpos = datagram_pos;
    p   = packet_pos;
    sel = packet_selected;
    afc = b[5:4];
    if (in_data.datagram_start) begin
      dpos = '0;
      p    = '0;
      sel  = 1'b0;
    end

    datagram_pos_next       = dpos;
    packet_pos_next         = p;
    packet_selected_next    = sel;
    pid_high_and_start_next = pid_high_and_start;
    adaptation_mode_next    = adaptation_mode;
    payload_start_pos_next  = payload_start_pos;
    unit_byte_count_next    = unit_byte_count;
    unit_open_next          = unit_open;
    result                  = '0;

    if (dpos < cfg.rtp_header_bytes) begin
      // still inside the RTP header
      datagram_pos_next = dpos + 8'd1;
    end else begin
      packet_pos_next = (p == LastPos) ? '0 : p + POS_W'(1);
      if (p == POS_W'(0)) begin
        packet_selected_next = 1'b0;
      end else if (p == POS_W'(1)) begin
        pid_high_and_start_next = {b[6], b[4:0]};
      end else if (p == POS_W'(2)) begin
        if ({pid_high_and_start[4:0], b} == cfg.target_pid) begin
          packet_selected_next = 1'b1;
          unit_open_next       = 1'b1;
          if (pid_high_and_start[5]) begin
            unit_byte_count_next = '0;
            if (unit_open) begin
              result.valid           = 1'b1;
              result.res.result_kind = KIND_ABANDON;
            end
          end
        end else begin
          packet_selected_next = 1'b0;
          if (unit_open) begin
            result.valid           = 1'b1;
            result.res.result_kind = KIND_END;
            unit_open_next         = 1'b0;
            unit_byte_count_next   = '0;
          end
        end
      end else if (p == POS_W'(3)) begin
        adaptation_mode_next = afc;
        if (sel) begin
          if (afc == AFC_PAYLOAD_ONLY) begin
            payload_start_pos_next = 8'd4;
          end else if (afc == AFC_AF_PAYLOAD) begin
            payload_start_pos_next = 8'hFF;
          end else begin
            packet_selected_next   = 1'b0;
            result.valid           = 1'b1;
            result.res.result_kind = KIND_BAD_AFC;
          end
        end
      end else if (sel) begin
        if (p == POS_W'(4) && adaptation_mode == AFC_AF_PAYLOAD) begin
          if (b > AfMax) begin
            packet_selected_next   = 1'b0;
            result.valid           = 1'b1;
            result.res.result_kind = KIND_AF_LONG;
          end else begin
            payload_start_pos_next = 8'd5 + b;
          end
        end else if (8'(p) >= payload_start_pos) begin
          if (unit_byte_count < cfg.unit_header_skip) begin
            unit_byte_count_next = unit_byte_count + 8'd1;
          end else begin
            result.valid           = 1'b1;
            result.res.out_byte    = b;
            result.res.result_kind = KIND_PAYLOAD;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      datagram_pos       <= '0;
      packet_pos         <= '0;
      pid_high_and_start <= '0;
      packet_selected    <= 1'b0;
      adaptation_mode    <= '0;
      payload_start_pos  <= '0;
      unit_byte_count    <= '0;
      unit_open          <= 1'b0;
    end else if (acc) begin
      datagram_pos       <= datagram_pos_next;
      packet_pos         <= packet_pos_next;
      pid_high_and_start <= pid_high_and_start_next;
      packet_selected    <= packet_selected_next;
      adaptation_mode    <= adaptation_mode_next;
      payload_start_pos  <= payload_start_pos_next;
      unit_byte_count    <= unit_byte_count_next;
      unit_open          <= unit_open_next;
    end
  end

endmodule

FILE: rtl/ts_pid_payload_extractor_top.sv
`timescale 1ns / 1ps
// Transport stream PID payload extractor, top level. Depends on tspe_pkg, tspe_parser.
// A result is loaded into the output register on the clock edge that accepts its byte.
// Throughput: one byte per cycle; the input stalls only while a held result is stalled.
// Reset (rst, synchronous): clears parser state and output valid, loads register defaults
// (target PID 0x1011, 12 RTP header bytes, 14 unit header bytes).
module ts_pid_payload_extractor_top
  import tspe_pkg::*;
#(
  parameter int TS_PACKET_BYTES = 188
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  cfg_t cfg;
  res_t result;
  logic acc;

  assign in_stall = out_valid & out_stall;
  assign acc      = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_pid       <= TARGET_PID_RST;
      cfg.rtp_header_bytes <= RTP_HEADER_RST;
      cfg.unit_header_skip <= UNIT_SKIP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET_PID: cfg.target_pid       <= cfg_data;
        CFG_RTP_HEADER: cfg.rtp_header_bytes <= cfg_data[7:0];
        CFG_UNIT_SKIP:  cfg.unit_header_skip <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  tspe_parser #(
    .TS_PACKET_BYTES(TS_PACKET_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .acc     (acc),
    .in_data (in_data),
    .cfg     (cfg),
    .result  (result)
  );

  // load a new result or drop the one just taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= result.valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && result.valid) begin
      out_data <= result.res;
    end
  end

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.result_kind <= KIND_AF_LONG))
    else $error("result kind out of range");

  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.result_kind != KIND_PAYLOAD) |-> (out_data.out_byte == 8'd0))
    else $error("marker result carries nonzero byte");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

endmodule

FILE: sim/tspe_extract_checker.sv
`timescale 1ns / 1ps
// Checker for the transport stream PID payload extractor: watches the byte, result and
// register ports, predicts each result request and compares it. Depends on tspe_pkg.
module tspe_extract_checker
  import tspe_pkg::*;
#(
  parameter int TS_PACKET_BYTES = 188
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        run_done,
  output int          mismatches,
  output int          outstanding,
  output int          results_checked
);

  localparam int AF_LEN_MAX  = TS_PACKET_BYTES - 5;
  localparam int MAX_REPORTS = 40;

  // register copies
  logic [12:0] cur_pid;
  logic [7:0]  cur_rtp;
  logic [7:0]  cur_skip;

  // parser state
  logic [7:0] dg_pos;
  logic [7:0] pkt_pos;
  logic [5:0] hdr_hi;
  logic       selected;
  logic [1:0] afc;
  logic [7:0] pay_start;
  logic [7:0] unit_cnt;
  logic       unit_open;

  out_t extracted_q[$];
  bit   leftover_checked;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t tspe check: %s", $time, what);
  endtask

  // Advance the parser by one datagram byte; hit is set when a result request follows.
  task automatic extract_byte(input in_t req, output bit hit, output out_t res);
    logic [7:0]  p;
    logic [12:0] pid;
    hit = 1'b0;
    res = '0;
    if (req.datagram_start) begin
      dg_pos   = '0;
      pkt_pos  = '0;
      selected = 1'b0;
    end
    if (dg_pos < cur_rtp) begin
      dg_pos = dg_pos + 8'd1;
    end else begin
      p = pkt_pos;
      if (p == 8'd0) begin
        selected = 1'b0;
      end else if (p == 8'd1) begin
        hdr_hi = {req.data_byte[6], req.data_byte[4:0]};
      end else if (p == 8'd2) begin
        pid = {hdr_hi[4:0], req.data_byte};
        if (pid == cur_pid) begin
          selected = 1'b1;
          // restart flag while a unit is open abandons it but keeps it open
          if (hdr_hi[5]) begin
            if (unit_open) begin
              hit = 1'b1;
              res.result_kind = KIND_ABANDON;
            end
            unit_cnt = '0;
          end
          unit_open = 1'b1;
        end else begin
          selected = 1'b0;
          if (unit_open) begin
            hit = 1'b1;
            res.result_kind = KIND_END;
            unit_open = 1'b0;
            unit_cnt  = '0;
          end
        end
      end else if (p == 8'd3) begin
        afc = req.data_byte[5:4];
        if (selected) begin
          if (afc == AFC_PAYLOAD_ONLY) begin
            pay_start = 8'd4;
          end else if (afc == AFC_AF_PAYLOAD) begin
            pay_start = 8'hFF;
          end else begin
            selected = 1'b0;
            hit = 1'b1;
            res.result_kind = KIND_BAD_AFC;
          end
        end
      end else if (selected) begin
        if (p == 8'd4 && afc == AFC_AF_PAYLOAD) begin
          if (int'(req.data_byte) > AF_LEN_MAX) begin
            selected = 1'b0;
            hit = 1'b1;
            res.result_kind = KIND_AF_LONG;
          end else begin
            pay_start = req.data_byte + 8'd5;
          end
        end else if (p >= pay_start) begin
          if (unit_cnt < cur_skip) begin
            unit_cnt = unit_cnt + 8'd1;
          end else begin
            hit = 1'b1;
            res.out_byte    = req.data_byte;
            res.result_kind = KIND_PAYLOAD;
          end
        end
      end
      if (int'(p) + 1 >= TS_PACKET_BYTES) pkt_pos = '0;
      else pkt_pos = p + 8'd1;
    end
  endtask

  always @(posedge clk) begin
    bit   hit;
    out_t pred;
    out_t want;
    if (rst) begin
      cur_pid   = TARGET_PID_RST;
      cur_rtp   = RTP_HEADER_RST;
      cur_skip  = UNIT_SKIP_RST;
      dg_pos    = '0;
      pkt_pos   = '0;
      hdr_hi    = '0;
      selected  = 1'b0;
      afc       = '0;
      pay_start = '0;
      unit_cnt  = '0;
      unit_open = 1'b0;
      extracted_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TARGET_PID: cur_pid  = cfg_data;
          CFG_RTP_HEADER: cur_rtp  = cfg_data[7:0];
          CFG_UNIT_SKIP:  cur_skip = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        extract_byte(in_data, hit, pred);
        if (hit) extracted_q.push_back(pred);
      end
      if (out_valid && !out_stall) begin
        results_checked++;
        if (extracted_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte %02h kind %0d",
                                    out_data.out_byte, out_data.result_kind));
        end else begin
          want = extracted_q.pop_front();
          if (out_data.result_kind !== want.result_kind)
            report_mismatch($sformatf("result_kind got %0d want %0d",
                                      out_data.result_kind, want.result_kind));
          if (out_data.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte got %02h want %02h (kind %0d)",
                                      out_data.out_byte, want.out_byte, want.result_kind));
        end
      end
      if (run_done && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (extracted_q.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", extracted_q.size()));
      end
      outstanding <= extracted_q.size();
    end
  end

endmodule

FILE: sim/ts_pid_payload_extractor_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the transport stream PID payload extractor: drives datagram bytes,
// register writes and output stalls. Depends on tspe_pkg and tspe_extract_checker.
module ts_pid_payload_extractor_top_tb;
  import tspe_pkg::*;

  localparam int TS_PACKET_BYTES  = 188;
  localparam int LIMIT_CYCLES     = 600000;
  localparam int DRAIN_LIMIT      = 20000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int HOLD_AFTER       = 80;
  localparam int CALM_AT          = 1800;

  localparam logic [7:0] TS_SYNC        = 8'h47;
  localparam logic [1:0] AFC_RESERVED   = 2'b00;
  localparam logic [1:0] AFC_AF_ONLY    = 2'b10;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        run_done;

  int mismatches;
  int outstanding;
  int results_checked;

  bit          calm;
  bit          mark_start;
  int          bytes_sent;
  int          stop_limit;
  int          settings_used;
  int          idle_pct;
  logic [12:0] pid_now;
  logic [7:0]  rtp_now;

  ts_pid_payload_extractor_top #(
    .TS_PACKET_BYTES(TS_PACKET_BYTES)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tspe_extract_checker #(
    .TS_PACKET_BYTES(TS_PACKET_BYTES)
  ) u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .run_done        (run_done),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("ts_pid_payload_extractor_top_tb: FAIL");
    $finish;
  end

  // Offer one byte request and hold it until accepted, with an optional idle burst first.
  task automatic send_item(input logic [7:0] d, input logic s);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: d, datagram_start: s};
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (bytes_sent >= CALM_AT) calm = 1'b1;
  endtask

  // Drop the rest of a datagram once the byte budget of the setting is spent.
  task automatic put_byte(input logic [7:0] d);
    if (bytes_sent < stop_limit) begin
      send_item(d, mark_start);
      mark_start = 1'b0;
    end
  endtask

  task automatic wait_drained();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    // cover the output register after the last result
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [12:0] pid, input logic [7:0] rtp,
                              input logic [7:0] skip);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TARGET_PID;
    cfg_data  <= pid;
    @(posedge clk);
    cfg_index <= CFG_RTP_HEADER;
    cfg_data  <= {5'd0, rtp};
    @(posedge clk);
    cfg_index <= CFG_UNIT_SKIP;
    cfg_data  <= {5'd0, skip};
    @(posedge clk);
    cfg_we  <= 1'b0;
    pid_now = pid;
    rtp_now = rtp;
  endtask

  task automatic send_ts_packet(input int len);
    logic [12:0] pid;
    bit          pusi;
    logic [1:0]  afc;
    logic [7:0]  af_len;
    logic [7:0]  b;
    int          r;
    pid  = ($urandom_range(0, 99) < 65) ? pid_now : 13'($urandom);
    pusi = $urandom_range(0, 99) < 40;
    r = $urandom_range(0, 99);
    afc = (r < 45) ? AFC_PAYLOAD_ONLY : (r < 85) ? AFC_AF_PAYLOAD :
          (r < 93) ? AFC_RESERVED : AFC_AF_ONLY;
    r = $urandom_range(0, 99);
    if (r < 50) af_len = 8'($urandom_range(0, 12));
    else if (r < 88) af_len = 8'($urandom_range(0, TS_PACKET_BYTES - 5));
    else af_len = 8'($urandom_range(TS_PACKET_BYTES - 4, 255));
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      case (i)
        0: if ($urandom_range(0, 4) != 0) b = TS_SYNC;
        1: b = {b[7], pusi, b[5], pid[12:8]};
        2: b = pid[7:0];
        3: b = {b[7:6], afc, b[3:0]};
        4: if (afc == AFC_AF_PAYLOAD) b = af_len;
        default: ;
      endcase
      put_byte(b);
    end
  endtask

  // One datagram: header bytes, full packets, maybe a cut-off packet at the end.
  task automatic send_datagram();
    int hdr_len;
    bit more;
    mark_start = 1'b1;
    hdr_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, rtp_now) : int'(rtp_now);
    repeat (hdr_len) put_byte(8'($urandom));
    if (hdr_len == rtp_now) begin
      more = 1'b1;
      while (more) begin
        if ($urandom_range(0, 99) < 35) begin
          send_ts_packet(TS_PACKET_BYTES);
          more = $urandom_range(0, 99) < 60;
        end else begin
          send_ts_packet($urandom_range(1, 40));
          more = 1'b0;
        end
      end
    end
  endtask

  task automatic run_setting(input logic [12:0] pid, input logic [7:0] rtp,
                             input logic [7:0] skip, input int nbytes, input int idle);
    int stop_at;
    wait_drained();
    program_regs(pid, rtp, skip);
    idle_pct = idle;
    settings_used++;
    stop_at = bytes_sent + nbytes;
    stop_limit = stop_at;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 99) < 6) begin
        // garbage with stray datagram starts
        repeat ($urandom_range(1, 20)) send_item(8'($urandom), $urandom_range(0, 9) == 0);
      end else begin
        send_datagram();
      end
    end
  endtask

  // Result side: random stall bursts, one long hold, no stalls near the end.
  initial begin
    int results_taken;
    int burst_left;
    bit long_hold_done;
    results_taken  = 0;
    burst_left     = 0;
    long_hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) results_taken++;
      if (!long_hold_done && results_taken >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else if (burst_left == 0) begin
        if ($urandom_range(0, 99) < 30) begin
          out_stall <= 1'b1;
          burst_left = $urandom_range(1, 9) - 1;
        end else begin
          out_stall <= 1'b0;
          burst_left = $urandom_range(1, 30) - 1;
        end
      end else begin
        burst_left--;
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_TARGET_PID;
    cfg_data  <= '0;
    run_done  <= 1'b0;
    calm       = 1'b0;
    mark_start = 1'b0;
    bytes_sent = 0;
    stop_limit = 0;
    settings_used = 1;
    idle_pct   = 15;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // short datagrams that stop right after the header fields
    program_regs(13'h1555, 8'd0, 8'd0);
    send_item(8'h00, 1'b1); send_item(8'hD5, 1'b0); send_item(8'h55, 1'b0);
    send_item(8'h10, 1'b0); send_item(8'hFF, 1'b0); send_item(8'h00, 1'b0);
    // restart while open, then adaptation-field-only control
    send_item(TS_SYNC, 1'b1); send_item(8'h55, 1'b0); send_item(8'h55, 1'b0);
    send_item(8'h20, 1'b0);
    // adaptation length one past the limit
    send_item(TS_SYNC, 1'b1); send_item(8'h15, 1'b0); send_item(8'h55, 1'b0);
    send_item(8'h30, 1'b0); send_item(8'hB8, 1'b0);
    // adaptation length at the limit
    send_item(TS_SYNC, 1'b1); send_item(8'h55, 1'b0); send_item(8'h55, 1'b0);
    send_item(8'hF3, 1'b0); send_item(8'hB7, 1'b0);
    // control zero
    send_item(TS_SYNC, 1'b1); send_item(8'h15, 1'b0); send_item(8'h55, 1'b0);
    send_item(8'h0F, 1'b0);
    // another PID closes the unit
    send_item(8'hFF, 1'b1); send_item(8'h00, 1'b0); send_item(8'h00, 1'b0);

    run_setting(TARGET_PID_RST, RTP_HEADER_RST, UNIT_SKIP_RST, 550, 20);
    run_setting(13'h0000, 8'h00, 8'h00, 550, 10);
    run_setting(13'h1FFF, 8'hFF, 8'hFF, 500, 30);
    run_setting(13'($urandom), 8'($urandom_range(1, 6)), 8'($urandom_range(0, 30)), 330, 5);

    wait_drained();
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    $display("Sent %0d datagram bytes under %0d register settings; %0d results compared.",
             bytes_sent, settings_used, results_checked);
    $display("Run included a %0d-cycle output hold, drains between settings, idle-free tail.",
             LONG_HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("ts_pid_payload_extractor_top_tb: PASS");
    end else begin
      $display("ts_pid_payload_extractor_top_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/tspe_pkg.sv
rtl/tspe_parser.sv
rtl/ts_pid_payload_extractor_top.sv
sim/tspe_extract_checker.sv
sim/ts_pid_payload_extractor_top_tb.sv
